FILE: rtl/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg
// Shared types, widths and codes for the regula falsi event time estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rfe_pkg;

  localparam int TIME_W     = 48;   // Q32.16
  localparam int ERR_W      = 32;   // Q16.16
  localparam int TOL_W      = 31;   // unsigned Q15.16
  localparam int MODE_W     = 2;
  localparam int ITER_W     = 5;
  localparam int DT_W       = TIME_W + 1;
  localparam int PROD_W     = ERR_W + TIME_W;  // |err| * |dt| fits in 80 bits
  localparam int DIV_STEPS  = TIME_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TOL_W;

  localparam int ITER_LIMIT_DEF = 20;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  // crossing mode and learned slope share one coding
  localparam logic [MODE_W-1:0] MODE_ANY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RISE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FALL = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL  = 1'b0,
    CFG_MODE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL0,
    D_MUL1,
    D_SUM,
    D_CHK,
    D_STEP,
    D_FIN
  } dstate_t;

  typedef struct packed {
    logic                    start;
    logic signed [ERR_W-1:0] err;
    logic signed [DT_W-1:0]  dt;
    logic [ERR_W-1:0]        dx;     // always positive when both brackets hold
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TIME_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/rfe_in_if.sv
// ----------------------------------------------------------------------------
// rfe_in_if
// Input channel: one time/error sample per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfe_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rfe_pkg::TIME_W-1:0] time_now;
  logic signed [rfe_pkg::ERR_W-1:0]  error_value;

  modport source (output valid, output time_now, output error_value, input ready);
  modport sink   (input valid, input time_now, input error_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/rfe_out_if.sv
// ----------------------------------------------------------------------------
// rfe_out_if
// Result channel: time-to-go estimate and no-estimate flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfe_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rfe_pkg::TIME_W-1:0] time_to_go;
  logic                              no_estimate;

  modport source (output valid, output time_to_go, output no_estimate, input ready);
  modport sink   (input valid, input time_to_go, input no_estimate, output ready);
endinterface

`default_nettype wire

FILE: rtl/rfe_muldiv.sv
// ----------------------------------------------------------------------------
// rfe_muldiv
// Shared multiply/divide unit: -err * dt / dx, truncated, saturated to 48 bits.
// One 32x32 multiplier used twice, then one restoring step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rfe_muldiv (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rfe_pkg::div_req_t req,
  output rfe_pkg::div_rsp_t      rsp
);

  localparam int EW = rfe_pkg::ERR_W;
  localparam int TW = rfe_pkg::TIME_W;
  localparam int DW = rfe_pkg::DT_W;

  rfe_pkg::dstate_t dstate_r, dstate_nxt;

  logic [EW-1:0]            a_r;        // |err|
  logic [DW-1:0]            b_r;        // |dt|
  logic [EW-1:0]            d_r;
  logic                     neg_r;
  logic [2*EW-1:0]          prod_r;
  logic [2*EW-1:0]          lo_r;
  logic [EW-1:0]            rem_r;
  logic [TW-1:0]            num_r;      // dividend bits in, quotient bits out
  logic                     ovf_r;
  logic [rfe_pkg::CNT_W-1:0] cnt_r;

  logic [EW-1:0]   mul_b;
  logic [2*EW-1:0] mul_p;
  logic [TW-1:0]   sum_hi;
  logic [EW:0]     cur;
  logic            ge;
  logic [EW:0]     cur_sub;
  logic [EW-1:0]   err_abs;
  logic [DW-1:0]   dt_abs;
  logic            step_last;
  logic signed [TW-1:0] sat_q;
  logic            step_ovf;

  // the one multiplier, fed the low or high slice of |dt|
  assign mul_b = (dstate_r == rfe_pkg::D_MUL0) ? b_r[EW-1:0] : EW'(b_r[DW-1:EW]);
  assign mul_p = a_r * mul_b;

  assign sum_hi  = prod_r[TW-1:0] + TW'(lo_r[2*EW-1:EW]);
  assign cur     = {rem_r, num_r[TW-1]};
  assign ge      = cur >= {1'b0, d_r};
  assign cur_sub = cur - {1'b0, d_r};

  assign err_abs = req.err[EW-1] ? EW'(-req.err) : EW'(req.err);
  assign dt_abs  = req.dt[DW-1]  ? DW'(-req.dt)  : DW'(req.dt);

  assign step_last = (cnt_r == rfe_pkg::CNT_W'(rfe_pkg::DIV_STEPS - 1));
  assign step_ovf  = ovf_r || num_r[TW-1];

  always_comb begin
    if (neg_r) begin
      sat_q = step_ovf ? {1'b1, {(TW-1){1'b0}}} : TW'(-num_r);
    end else begin
      sat_q = step_ovf ? {1'b0, {(TW-1){1'b1}}} : num_r;
    end
  end

  // next state
  always_comb begin
    dstate_nxt = dstate_r;
    unique case (dstate_r)
      rfe_pkg::D_IDLE: if (req.start) dstate_nxt = rfe_pkg::D_MUL0;
      rfe_pkg::D_MUL0: dstate_nxt = rfe_pkg::D_MUL1;
      rfe_pkg::D_MUL1: dstate_nxt = rfe_pkg::D_SUM;
      rfe_pkg::D_SUM:  dstate_nxt = rfe_pkg::D_CHK;
      rfe_pkg::D_CHK:  dstate_nxt = rfe_pkg::D_STEP;
      rfe_pkg::D_STEP: if (step_last) dstate_nxt = rfe_pkg::D_FIN;
      rfe_pkg::D_FIN:  dstate_nxt = rfe_pkg::D_IDLE;
      default:         dstate_nxt = rfe_pkg::D_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = 1'b0;
    rsp.quot = sat_q;
    unique case (dstate_r)
      rfe_pkg::D_FIN: rsp.done = 1'b1;
      default:        rsp.done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= rfe_pkg::D_IDLE;
    end else begin
      dstate_r <= dstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (dstate_r)
      rfe_pkg::D_IDLE: begin
        a_r   <= err_abs;
        b_r   <= dt_abs;
        d_r   <= req.dx;
        neg_r <= (req.err > 0 && req.dt > 0) || (req.err < 0 && req.dt < 0);
      end
      rfe_pkg::D_MUL0: prod_r <= mul_p;
      rfe_pkg::D_MUL1: begin
        lo_r   <= prod_r;
        prod_r <= mul_p;
      end
      rfe_pkg::D_SUM: begin
        rem_r <= sum_hi[TW-1:TW-EW];
        num_r <= {sum_hi[TW-EW-1:0], lo_r[EW-1:0]};
      end
      rfe_pkg::D_CHK: begin
        // quotient of 2^48 or more cannot be represented: saturate
        ovf_r <= rem_r >= d_r;
        cnt_r <= '0;
      end
      rfe_pkg::D_STEP: begin
        rem_r <= ge ? cur_sub[EW-1:0] : cur[EW-1:0];
        num_r <= {num_r[TW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> dstate_r == rfe_pkg::D_IDLE)
    else $error("divide unit started while busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/regula_falsi_event_time_estimator_core.sv
// ----------------------------------------------------------------------------
// regula_falsi_event_time_estimator_core
// False-position time-to-go estimator with bracket tracking and crossing modes.
// ----------------------------------------------------------------------------
// Sequence: an accepted word is evaluated and its result loaded into the output
//   register; when an estimate is computed, the divide unit runs first (2
//   multiply passes, a range check and 48 divide steps).
// Throughput: one word at a time; the next word is taken only once the result
//   is loaded, which waits until the previous result has left the output.
// Reset: synchronous, active low; clears brackets, counters and output valid,
//   tolerance returns to 66 and crossing mode to any.
`default_nettype none

module regula_falsi_event_time_estimator_core #(
  parameter int ITER_LIMIT = rfe_pkg::ITER_LIMIT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  rfe_in_if.sink                                 in_ch,
  rfe_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [rfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rfe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int EW = rfe_pkg::ERR_W;
  localparam int TW = rfe_pkg::TIME_W;
  localparam int IW = rfe_pkg::ITER_W;
  localparam int MW = rfe_pkg::MODE_W;
  localparam logic [IW-1:0] ITER_LIM_C = ITER_LIMIT[IW-1:0];

  rfe_pkg::state_t state_r, state_nxt;

  // configuration
  logic [rfe_pkg::TOL_W-1:0] tol_r;
  logic [MW-1:0]             mode_r;

  // estimator state
  logic [IW-1:0]        iter_r;
  logic                 lv_r, uv_r;
  logic signed [EW-1:0] le_r, ue_r, prev_r;
  logic signed [TW-1:0] lt_r, ut_r;
  logic [MW-1:0]        slope_r;

  // captured word and pending result
  logic signed [TW-1:0] t_r;
  logic signed [EW-1:0] e_r;
  logic                 need_div_r;
  logic signed [TW-1:0] res_tgo_r;
  logic                 res_noest_r;

  // output register
  logic                 out_valid_r;
  logic signed [TW-1:0] out_tgo_r;
  logic                 out_noest_r;

  rfe_pkg::div_req_t div_req;
  rfe_pkg::div_rsp_t div_rsp;

  logic          in_take, out_load;
  logic [EW-1:0] abs_e;
  logic [EW:0]   diff, abs_diff;
  logic          in_tol, close, mode_ok, conv;
  logic          e_neg, e_pos, lv_n, uv_n, both, match;
  logic [IW-1:0] iter_n;

  // ---- evaluation of the captured word against the old state ----
  assign abs_e    = e_r[EW-1] ? EW'(-e_r) : EW'(e_r);
  assign diff     = {prev_r[EW-1], prev_r} - {e_r[EW-1], e_r};
  assign abs_diff = diff[EW] ? (EW+1)'(-diff) : diff;
  assign in_tol   = abs_e < {1'b0, tol_r};
  assign close    = abs_diff < {2'b00, tol_r};
  assign mode_ok  = (mode_r == rfe_pkg::MODE_ANY) ||
                    (mode_r == rfe_pkg::MODE_RISE && lv_r) ||
                    (mode_r == rfe_pkg::MODE_FALL && uv_r);
  assign conv     = (iter_r != '0) && (in_tol || close) && mode_ok;

  assign e_neg  = e_r[EW-1];
  assign e_pos  = !e_r[EW-1] && (e_r != '0);
  assign lv_n   = lv_r || e_neg;
  assign uv_n   = uv_r || e_pos;
  assign both   = lv_n && uv_n;
  assign iter_n = (iter_r == '1) ? iter_r : iter_r + 1'b1;
  assign match  = (mode_r == rfe_pkg::MODE_ANY) ||
                  (mode_r == rfe_pkg::MODE_RISE && slope_r == rfe_pkg::MODE_RISE) ||
                  (mode_r == rfe_pkg::MODE_FALL && slope_r == rfe_pkg::MODE_FALL);

  // ---- divide unit, fed from the updated brackets ----
  always_comb begin
    div_req.start = 1'b0;
    div_req.err   = e_r;
    div_req.dt    = {ut_r[TW-1], ut_r} - {lt_r[TW-1], lt_r};
    div_req.dx    = EW'(ue_r - le_r);
    unique case (state_r)
      rfe_pkg::ST_DIV: div_req.start = 1'b1;
      default:         div_req.start = 1'b0;
    endcase
  end

  rfe_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfe_pkg::ST_IDLE: if (in_ch.valid) state_nxt = rfe_pkg::ST_EVAL;
      rfe_pkg::ST_EVAL: state_nxt = (!conv && both && match && !in_tol &&
                                     iter_n <= ITER_LIM_C) ? rfe_pkg::ST_DIV
                                                           : rfe_pkg::ST_DONE;
      rfe_pkg::ST_DIV:  state_nxt = rfe_pkg::ST_WAIT;
      rfe_pkg::ST_WAIT: if (div_rsp.done) state_nxt = rfe_pkg::ST_DONE;
      rfe_pkg::ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = rfe_pkg::ST_IDLE;
      default:          state_nxt = rfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      rfe_pkg::ST_IDLE: in_ch.ready = 1'b1;
      rfe_pkg::ST_DONE: out_load    = !out_valid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        out_load    = 1'b0;
      end
    endcase
  end

  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= rfe_pkg::TOL_RESET;
      mode_r <= rfe_pkg::MODE_ANY;
    end else if (cfg_we) begin
      unique case (rfe_pkg::cfg_idx_t'(cfg_index))
        rfe_pkg::CFG_TOL:  tol_r  <= cfg_wdata;
        rfe_pkg::CFG_MODE: mode_r <= cfg_wdata[MW-1:0];
        default: ;
      endcase
    end
  end

  // ---- word capture ----
  always_ff @(posedge clk) begin
    if (in_take) begin
      t_r <= in_ch.time_now;
      e_r <= in_ch.error_value;
    end
  end

  // ---- estimator state update ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r  <= '0;
      lv_r    <= 1'b0;
      uv_r    <= 1'b0;
      le_r    <= '0;
      ue_r    <= '0;
      lt_r    <= '0;
      ut_r    <= '0;
      prev_r  <= '0;
      slope_r <= rfe_pkg::MODE_ANY;
    end else if (state_r == rfe_pkg::ST_EVAL && !conv) begin
      if (e_neg) begin
        le_r <= e_r;
        lt_r <= t_r;
      end
      if (e_pos) begin
        ue_r <= e_r;
        ut_r <= t_r;
      end
      // slope disagrees with the requested crossing: drop that side
      lv_r   <= lv_n && !(both && !match && mode_r == rfe_pkg::MODE_RISE);
      uv_r   <= uv_n && !(both && !match && mode_r == rfe_pkg::MODE_FALL);
      iter_r <= (both && match) ? iter_n : '0;
      if (both && match) begin
        prev_r <= e_r;
      end else if (both) begin
        slope_r <= rfe_pkg::MODE_ANY;
      end else if (lv_n) begin
        slope_r <= rfe_pkg::MODE_RISE;
      end else if (uv_n) begin
        slope_r <= rfe_pkg::MODE_FALL;
      end
    end
  end

  // ---- pending result ----
  always_ff @(posedge clk) begin
    if (state_r == rfe_pkg::ST_EVAL) begin
      res_tgo_r   <= '0;
      res_noest_r <= !conv && !(both && match);
      need_div_r  <= state_nxt == rfe_pkg::ST_DIV;
    end else if (state_r == rfe_pkg::ST_WAIT && div_rsp.done && need_div_r) begin
      res_tgo_r <= div_rsp.quot;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tgo_r   <= res_tgo_r;
      out_noest_r <= res_noest_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.time_to_go  = out_tgo_r;
  assign out_ch.no_estimate = out_noest_r;

`ifndef ASSERT_OFF
  a_take_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == rfe_pkg::ST_EVAL)
    else $error("accepted word not evaluated next cycle");

  a_noest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_noest_r) |-> out_tgo_r == '0)
    else $error("no-estimate word carries a non-zero time-to-go");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == rfe_pkg::ST_WAIT)
    else $error("divide result arrived outside wait state");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the false-position time-to-go estimator. Samples go
// in through the input channel, and a cycle-free model of the bracket logic
// predicts each result word, which is then compared field by field. The run
// covers field extremes, the crossing modes, tolerance extremes, the iteration
// limit, ramps with random content and raw noise, first under random idling on
// both channels and then in a run with idling off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW = rfe_pkg::TIME_W;
  localparam int EW = rfe_pkg::ERR_W;
  localparam int MW = rfe_pkg::MODE_W;
  localparam int DW = rfe_pkg::CFG_DATA_W;

  localparam logic [MW-1:0] MODE_RSVD = 2'd3;   // unnamed fourth crossing mode
  localparam logic [rfe_pkg::TOL_W-1:0] TOL_MAX = '1;
  localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [EW-1:0] E_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] E_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam int ONE            = 65536;            // 1.0 in either format
  localparam int ITER_CAP       = rfe_pkg::ITER_LIMIT_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 70;

  typedef struct packed {
    logic signed [TW-1:0] time_to_go;
    logic                 no_estimate;
  } tgo_word_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rfe_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [DW-1:0]                   cfg_wdata;

  rfe_in_if  in_ch ();
  rfe_out_if out_ch ();

  regula_falsi_event_time_estimator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state and register copies
  logic [rfe_pkg::TOL_W-1:0]  tol_q;
  logic [MW-1:0]              mode_q;
  logic [rfe_pkg::ITER_W-1:0] iter_q;
  logic                       lo_ok, hi_ok;
  logic signed [EW-1:0]       lo_err_q, hi_err_q, last_err_q;
  logic signed [TW-1:0]       lo_t_q, hi_t_q;
  logic [MW-1:0]              slope_q;

  tgo_word_t pending_tgo[$];
  int        n_fail      = 0;
  int        n_samples   = 0;
  int        idle_cycles = 0;
  bit        gaps_on     = 1'b1;
  bit        stall_on    = 1'b1;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // -err * span_t / span_e, magnitude truncated, saturated to 48 bits
  function automatic logic signed [TW-1:0] false_position(
      input logic signed [63:0] err, input logic signed [63:0] span_t,
      input logic signed [63:0] span_e);
    logic [127:0] num, quo;
    logic         neg;
    if (span_e <= 0) return '0;
    num = {64'd0, mag64(err)} * {64'd0, mag64(span_t)};
    quo = num / {64'd0, span_e};
    neg = (err > 0 && span_t > 0) || (err < 0 && span_t < 0);
    if (neg) return (quo >= (128'd1 << (TW-1))) ? T_MIN : -quo[TW-1:0];
    return (quo > (128'd1 << (TW-1)) - 1) ? T_MAX : quo[TW-1:0];
  endfunction

  function automatic tgo_word_t next_time_to_go(input logic signed [TW-1:0] t_now,
                                                input logic signed [EW-1:0] e_now);
    tgo_word_t          r;
    logic signed [63:0] e64, d64, span_t, span_e;
    logic               near_zero, settled;
    r         = '0;
    e64       = 64'(e_now);
    d64       = 64'(last_err_q) - e64;
    near_zero = mag64(e64) < 64'(tol_q);
    settled   = (iter_q != '0) && (near_zero || mag64(d64) < 64'(tol_q));
    if (settled && (mode_q == rfe_pkg::MODE_ANY ||
                    (mode_q == rfe_pkg::MODE_RISE && lo_ok) ||
                    (mode_q == rfe_pkg::MODE_FALL && hi_ok)))
      return r;

    if (e_now < 0) begin
      lo_err_q = e_now;
      lo_t_q   = t_now;
      lo_ok    = 1'b1;
    end else if (e_now > 0) begin
      hi_err_q = e_now;
      hi_t_q   = t_now;
      hi_ok    = 1'b1;
    end
    if (iter_q != '1) iter_q = iter_q + 1'b1;

    if (lo_ok && hi_ok) begin
      if (!near_zero) begin
        span_t = 64'(hi_t_q) - 64'(lo_t_q);
        span_e = 64'(hi_err_q) - 64'(lo_err_q);
        r.time_to_go = false_position(e64, span_t, span_e);
        if (iter_q > ITER_CAP) r.time_to_go = '0;
      end
      if (mode_q == rfe_pkg::MODE_ANY ||
          (mode_q == rfe_pkg::MODE_RISE && slope_q == rfe_pkg::MODE_RISE) ||
          (mode_q == rfe_pkg::MODE_FALL && slope_q == rfe_pkg::MODE_FALL)) begin
        last_err_q = e_now;
        return r;
      end
      if (mode_q == rfe_pkg::MODE_RISE) lo_ok = 1'b0;
      else if (mode_q == rfe_pkg::MODE_FALL) hi_ok = 1'b0;
      slope_q = rfe_pkg::MODE_ANY;
    end else if (lo_ok) begin
      slope_q = rfe_pkg::MODE_RISE;
    end else if (hi_ok) begin
      slope_q = rfe_pkg::MODE_FALL;
    end
    iter_q        = '0;
    r.time_to_go  = '0;
    r.no_estimate = 1'b1;
    return r;
  endfunction

  // both channels and the register port sampled on the rising edge
  always @(posedge clk) begin : chk
    tgo_word_t want;
    logic      moved;
    moved = 1'b0;
    if (!rst_n) begin
      tol_q      = rfe_pkg::TOL_RESET;
      mode_q     = rfe_pkg::MODE_ANY;
      iter_q     = '0;
      lo_ok      = 1'b0;
      hi_ok      = 1'b0;
      lo_err_q   = '0;
      hi_err_q   = '0;
      last_err_q = '0;
      lo_t_q     = '0;
      hi_t_q     = '0;
      slope_q    = rfe_pkg::MODE_ANY;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rfe_pkg::CFG_TOL:  tol_q  = cfg_wdata;
          rfe_pkg::CFG_MODE: mode_q = cfg_wdata[MW-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_tgo.size() == 0) begin
          $error("unexpected result word: time_to_go %0d, no_estimate %0b",
                 out_ch.time_to_go, out_ch.no_estimate);
          n_fail++;
        end else begin
          want = pending_tgo.pop_front();
          if (out_ch.time_to_go !== want.time_to_go) begin
            $error("time_to_go: expected %0d, got %0d", want.time_to_go, out_ch.time_to_go);
            n_fail++;
          end
          if (out_ch.no_estimate !== want.no_estimate) begin
            $error("no_estimate: expected %0b, got %0b", want.no_estimate,
                   out_ch.no_estimate);
            n_fail++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        pending_tgo.push_back(next_time_to_go(in_ch.time_now, in_ch.error_value));
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result-side back-pressure in bursts
  always begin
    @(negedge clk);
    if (stall_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    out_ch.ready = 1'b1;
  end

  // leaves valid high on return; the next call or settle_idle moves it on
  task automatic drive_sample(input logic signed [TW-1:0] t_now,
                              input logic signed [EW-1:0] e_now);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.time_now    = t_now;
    in_ch.error_value = e_now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_samples++;
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_tgo.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input rfe_pkg::cfg_idx_t idx, input logic [DW-1:0] val);
    settle_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // straight-line error against time, error clamped to Q16.16
  task automatic drive_ramp(input logic signed [63:0] t0, input logic signed [63:0] h,
                            input logic signed [63:0] e0, input logic signed [63:0] de,
                            input int n);
    logic signed [63:0] e;
    for (int i = 0; i < n; i++) begin
      e = e0 + de * 64'(i);
      if (e > 64'sh7FFF_FFFF) e = 64'sh7FFF_FFFF;
      else if (e < -64'sh8000_0000) e = -64'sh8000_0000;
      drive_sample(TW'(t0 + h * 64'(i)), EW'(e));
    end
  endtask

  task automatic test_directed();
    drive_sample('0, '0);                          // no bracket yet
    drive_sample(T_MAX, E_MAX);
    drive_sample(T_MIN, E_MIN);                    // widest span, saturates
    drive_sample(T_MIN + 1, 32'sd1);               // inside tolerance
    drive_sample(T_MIN + 2, 32'sd65);
    drive_sample(T_MIN + 3, 32'sd66);              // just on tolerance
    drive_sample(T_MIN + 4, -32'sd66);
    drive_sample(T_MIN + 4, ONE);                  // equal bracket times
    drive_sample(TW'(10 * ONE), -2 * ONE);
    drive_sample(TW'(11 * ONE), -ONE);
    drive_sample(TW'(12 * ONE), ONE / 2);
    drive_sample(TW'(12 * ONE + ONE / 4), -ONE / 4);
    drive_sample(TW'(12 * ONE + ONE / 2), ONE / 8);
    drive_sample(TW'(13 * ONE), '0);
    drive_sample(TW'(-5 * ONE), 3 * ONE);          // time runs backwards
    drive_sample(T_MAX, -E_MAX);
    drive_sample(T_MIN, E_MAX);
  endtask

  task automatic test_crossing_modes();
    logic [MW-1:0] m;
    for (int k = 0; k < 3; k++) begin
      m = (k == 0) ? rfe_pkg::MODE_RISE : (k == 1) ? rfe_pkg::MODE_FALL : MODE_RSVD;
      write_reg(rfe_pkg::CFG_MODE, DW'(m));
      drive_ramp(64'(100 * ONE), 64'(ONE), 64'(-3 * ONE), 64'(ONE), 7);
      drive_ramp(64'(110 * ONE), 64'(ONE), 64'(3 * ONE), 64'(-ONE), 7);
      // steps finer than the tolerance
      drive_ramp(64'(120 * ONE), 64'(ONE / 4), -64'sd500, 64'sd40, 4);
    end
    write_reg(rfe_pkg::CFG_MODE, DW'(rfe_pkg::MODE_ANY));
  endtask

  task automatic test_tolerance_limits();
    logic signed [EW-1:0] e;
    // zero tolerance: nothing converges, so the iteration count runs past its cap
    write_reg(rfe_pkg::CFG_TOL, '0);
    for (int i = 0; i < 36; i++) begin
      e = $urandom_range(1, 1 << 20);
      if (i % 2 == 0) e = -e;
      if (i == 17) e = '0;                         // zero error loads neither bracket
      drive_sample(TW'(200 * ONE + i * ONE), e);
    end
    write_reg(rfe_pkg::CFG_TOL, TOL_MAX);
    drive_ramp(64'(300 * ONE), 64'(ONE), 64'(E_MIN), 64'sh1000_0000, 6);
    write_reg(rfe_pkg::CFG_MODE, DW'(rfe_pkg::MODE_RISE));
    drive_ramp(64'(310 * ONE), 64'(ONE), 64'sh4000_0000, -64'sh2000_0000, 4);
    write_reg(rfe_pkg::CFG_MODE, DW'(rfe_pkg::MODE_ANY));
    write_reg(rfe_pkg::CFG_TOL, rfe_pkg::TOL_RESET);
  endtask

  task automatic test_random(input int target);
    int                 n, c, x;
    logic signed [63:0] e0, de, t0, h;
    logic [63:0]        raw;
    while (n_samples < target) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(rfe_pkg::CFG_TOL, '0);
          1:       write_reg(rfe_pkg::CFG_TOL, TOL_MAX);
          2:       write_reg(rfe_pkg::CFG_TOL, DW'($urandom_range(0, 200)));
          default: write_reg(rfe_pkg::CFG_TOL, DW'($urandom) >> $urandom_range(0, 30));
        endcase
      end
      if ($urandom_range(0, 4) == 0)
        write_reg(rfe_pkg::CFG_MODE, DW'($urandom_range(0, 3)));
      n = $urandom_range(4, 20);
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < n; i++) begin
          raw = {$urandom, $urandom};
          drive_sample(raw[TW-1:0], EW'($urandom));
        end
      end else begin
        // ramp through zero around sample c, then on past it
        x  = $urandom_range(4, 30);
        e0 = 64'($urandom_range(1, 32'd1 << x));
        if ($urandom_range(0, 1) == 0) e0 = -e0;
        c  = $urandom_range(1, n - 1);
        de = -e0 / 64'(c) + $signed(64'($urandom_range(0, 6))) - 64'sd3;
        if (de == 0) de = (e0 > 0) ? -64'sd1 : 64'sd1;
        raw = {$urandom, $urandom};
        t0  = 64'($signed(raw[TW-1:0]));
        t0  = t0 >>> $urandom_range(0, 40);
        h   = 64'($urandom_range(0, 32'd1 << $urandom_range(0, 24)));
        if ($urandom_range(0, 9) == 0) h = -h;
        drive_ramp(t0, h, e0, de, n);
      end
    end
  endtask

  task automatic test_full_rate(input int target);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_random(target);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = rfe_pkg::CFG_TOL;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.time_now    = '0;
    in_ch.error_value = '0;
    out_ch.ready      = 1'b1;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_crossing_modes();
    test_tolerance_limits();
    test_random(520);
    test_full_rate(600);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_tgo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
